### rtl/core/iralloc_pkg.sv
// ----------------------------------------------------------------------------
// Interval resource allocator package
// Shared constants, widths and the sequencer state type.
// ----------------------------------------------------------------------------
package iralloc_pkg;

    localparam int MAX_CARS_DEFAULT = 16;

    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int CARID_W  = 4;
    localparam int POOL_W   = 5;

    localparam logic [POOL_W-1:0] POOL_RESET = 5'd16;

    // Input tdata: request_id, pickup_time, return_time.
    localparam int S_TDATA_W = 80;
    // Output tdata: echo_id, car_id, zero fill to 24 bits.
    localparam int M_TDATA_W = 24;

    localparam logic STATUS_ASSIGNED = 1'b0;
    localparam logic STATUS_NO_CAR   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

endpackage

### rtl/core/iralloc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iralloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/interval_resource_allocator_top.sv
// ----------------------------------------------------------------------------
// Interval resource allocator
// Assigns each rental request to the lowest-numbered free car.
// ----------------------------------------------------------------------------
// Each accepted request runs a scan that reads one car's return time per cycle
// from the return-time RAM and checks it against the pickup time with a single
// shared comparator. Freed cars and the first free car in the pool are found
// during that scan; the chosen car's return time is written back afterwards.
// The result sits in an output register, so the next request can be taken
// while it waits. Requests must arrive in nondecreasing pickup order. Write
// cars_in_use only while the block is idle.
// ----------------------------------------------------------------------------
module interval_resource_allocator_top #(
    parameter int MAX_CARS = iralloc_pkg::MAX_CARS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [iralloc_pkg::POOL_W-1:0]       cfg_wdata,   // cars_in_use

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] request_id, [47:16] pickup_time, [79:48] return_time
    input  logic [iralloc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] new_batch
    input  logic                                 s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] echo_id, [19:16] car_id, [23:20] zero
    output logic [iralloc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] status
    output logic                                 m_axis_tuser
);

    localparam int IDX_W = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CNT_W = $clog2(MAX_CARS + 1);
    localparam int EXT_W = (IDX_W >= iralloc_pkg::CARID_W) ? IDX_W : iralloc_pkg::CARID_W;
    localparam int FILL_W = iralloc_pkg::M_TDATA_W - iralloc_pkg::ID_W - iralloc_pkg::CARID_W;

    iralloc_pkg::state_t state_reg, state_next;

    logic [iralloc_pkg::POOL_W-1:0] pool_cfg_reg;
    logic [MAX_CARS-1:0]            busy_reg, busy_next;

    logic [iralloc_pkg::ID_W-1:0]   id_reg;
    logic [iralloc_pkg::TIME_W-1:0] pickup_reg;
    logic [iralloc_pkg::TIME_W-1:0] ret_reg;
    logic                           fresh_reg;
    logic [CNT_W-1:0]               pool_reg;

    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] chosen_reg, chosen_next;

    logic                           out_valid_reg, out_valid_next;
    logic [iralloc_pkg::ID_W-1:0]   out_id_reg;
    logic [iralloc_pkg::CARID_W-1:0] out_car_reg;
    logic                           out_status_reg;

    logic                           accept;
    logic                           out_free;
    logic                           rd_en;
    logic [iralloc_pkg::TIME_W-1:0] rd_data;
    logic                           ram_we;
    logic                           car_clear;
    logic                           car_still_busy;
    logic [CNT_W-1:0]               pool_size;
    logic [EXT_W-1:0]               chosen_ext;
    logic                           load_out;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign rd_en    = (state_reg == iralloc_pkg::ST_SCAN) && (rd_cnt_reg < CNT_W'(MAX_CARS));
    assign ram_we   = (state_reg == iralloc_pkg::ST_WRITE) && found_reg;
    assign load_out = (state_reg == iralloc_pkg::ST_WRITE) && out_free;

    assign s_axis_tready = (state_reg == iralloc_pkg::ST_IDLE);

    // A register value above the pool limit counts as the whole pool.
    always_comb
    begin
        if (32'(pool_cfg_reg) > MAX_CARS)
        begin
            pool_size = CNT_W'(MAX_CARS);
        end
        else
        begin
            pool_size = CNT_W'(pool_cfg_reg);
        end
    end

    iralloc_ram #(
        .WIDTH (iralloc_pkg::TIME_W),
        .DEPTH (MAX_CARS)
    ) u_ret_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (chosen_reg),
        .wdata (ret_reg),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    // Shared comparator: the car under test leaves when its return time has passed.
    assign car_clear      = fresh_reg || (rd_data <= pickup_reg);
    assign car_still_busy = busy_reg[cmp_idx_reg] && !car_clear;

    always_comb
    begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        rd_cnt_next  = rd_cnt_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        chosen_next  = chosen_reg;

        unique case (state_reg)
            iralloc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rd_cnt_next = '0;
                    found_next  = 1'b0;
                    chosen_next = '0;
                    state_next  = iralloc_pkg::ST_SCAN;
                end
            end
            iralloc_pkg::ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg)
                begin
                    busy_next[cmp_idx_reg] = car_still_busy;
                    if (!car_still_busy && !found_reg && (CNT_W'(cmp_idx_reg) < pool_reg))
                    begin
                        found_next  = 1'b1;
                        chosen_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == IDX_W'(MAX_CARS - 1))
                    begin
                        state_next = iralloc_pkg::ST_WRITE;
                    end
                end
            end
            iralloc_pkg::ST_WRITE:
            begin
                if (found_reg)
                begin
                    busy_next[chosen_reg] = 1'b1;
                end
                if (out_free)
                begin
                    state_next = iralloc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iralloc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iralloc_pkg::ST_IDLE;
            pool_cfg_reg  <= iralloc_pkg::POOL_RESET;
            busy_reg      <= '0;
            rd_cnt_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                pool_cfg_reg <= cfg_wdata;
            end
        end
    end

    assign chosen_ext = EXT_W'(chosen_reg);

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        chosen_reg  <= chosen_next;
        if (accept)
        begin
            id_reg     <= s_axis_tdata[15:0];
            pickup_reg <= s_axis_tdata[47:16];
            ret_reg    <= s_axis_tdata[79:48];
            fresh_reg  <= s_axis_tuser;
            pool_reg   <= pool_size;
        end
        if (load_out)
        begin
            out_id_reg <= id_reg;
            if (found_reg)
            begin
                out_car_reg    <= chosen_ext[iralloc_pkg::CARID_W-1:0];
                out_status_reg <= iralloc_pkg::STATUS_ASSIGNED;
            end
            else
            begin
                out_car_reg    <= '0;
                out_status_reg <= iralloc_pkg::STATUS_NO_CAR;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{FILL_W{1'b0}}, out_car_reg, out_id_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule
